// ===== rtl/ssc_pkg.sv =====
// shared types, register codes and byte helpers for the substring search core
`timescale 1ns / 1ps

package ssc_pkg;

	localparam int PAT_BYTES  = 16;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 6;
	localparam int LEN_W      = 5;

	typedef enum logic [2:0] {
		REG_CASE_FOLD = 3'd0,
		REG_BACKWARD  = 3'd1,
		REG_PAT_LEN   = 3'd2,
		REG_PAT_LO    = 3'd3,
		REG_PAT_HI    = 3'd4,
		REG_START     = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic last;
		logic cand;
		logic at_or_after;
		logic at_or_before;
	} item_flags_t;

	localparam int FLAGS_W = $bits(item_flags_t);

	function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
		logic [7:0] r;
		r = c;
		if (en && (c inside {[8'h41:8'h5A]})) begin
			r = c + 8'd32;
		end
		return r;
	endfunction

	function automatic logic [7:0] pattern_byte(input logic [63:0] lo, input logic [63:0] hi,
			input logic [LEN_W-1:0] idx);
		logic [7:0] r;
		r = 8'h00;
		if (!idx[4]) begin
			if (idx[3]) begin
				r = hi[{idx[2:0], 3'b000} +: 8];
			end else begin
				r = lo[{idx[2:0], 3'b000} +: 8];
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/ssc_front.sv =====
// front end: takes text bytes, folds case, tracks position and classifies candidates
`timescale 1ns / 1ps

module ssc_front #(
	parameter int POSITION_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         text_valid,
	input  logic [7:0]                   text_byte,
	input  logic                         last_byte,
	input  logic                         queue_ready,
	input  logic                         case_fold,
	input  logic [ssc_pkg::LEN_W-1:0]    query_len,
	input  logic [31:0]                  start_position,
	output logic                         push_valid,
	output logic [7:0]                   push_byte,
	output logic [POSITION_BITS-1:0]     push_pos,
	output ssc_pkg::item_flags_t         push_flags
);

	localparam int CW = (POSITION_BITS > 32) ? POSITION_BITS : 32;
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	logic [POSITION_BITS-1:0] count_q;
	logic [ssc_pkg::LEN_W-1:0] qm1;
	logic [POSITION_BITS-1:0] pos;
	logic accept;

	assign accept = text_valid && queue_ready;
	assign qm1    = query_len - 5'd1;
	assign pos    = count_q - POSITION_BITS'(qm1);

	always_comb begin
		push_flags.last         = last_byte;
		push_flags.cand         = (query_len != '0) && (count_q >= POSITION_BITS'(qm1));
		push_flags.at_or_after  = CW'(pos) >= CW'(start_position);
		push_flags.at_or_before = CW'(pos) <= CW'(start_position);
	end

	assign push_valid = text_valid;
	assign push_byte  = ssc_pkg::fold_byte(text_byte, case_fold);
	assign push_pos   = pos;

	// position counter, saturating, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (last_byte) begin
				count_q <= '0;
			end else if (count_q != POS_MAX) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

endmodule

// ===== rtl/ssc_queue.sv =====
// two-entry queue between front and back end
`timescale 1ns / 1ps

module ssc_queue #(
	parameter int WIDTH = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	input  logic [WIDTH-1:0] push_data,
	output logic             push_ready,
	output logic             pop_valid,
	output logic [WIDTH-1:0] pop_data,
	input  logic             pop
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != 2'd2;
	assign pop_valid  = count_q != 2'd0;
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/ssc_back.sv =====
// back end: byte window, full-window compare, match tracking and result register
`timescale 1ns / 1ps

module ssc_back #(
	parameter int MAX_QUERY     = 16,
	parameter int POSITION_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         entry_valid,
	input  logic [7:0]                   entry_byte,
	input  logic [POSITION_BITS-1:0]     entry_pos,
	input  ssc_pkg::item_flags_t         entry_flags,
	output logic                         entry_pop,
	input  logic                         case_fold,
	input  logic                         backward_mode,
	input  logic [ssc_pkg::LEN_W-1:0]    query_len,
	input  logic [63:0]                  pat_lo,
	input  logic [63:0]                  pat_hi,
	input  logic [31:0]                  start_position,
	input  logic                         result_ready,
	output logic                         result_valid,
	output logic                         found,
	output logic [31:0]                  match_position
);

	logic [7:0]               win_q [MAX_QUERY];
	logic [7:0]               new_win [MAX_QUERY];
	logic                     hit_seen_q;
	logic [POSITION_BITS-1:0] hit_pos_q;
	logic                     result_valid_q;
	logic                     found_q;
	logic [31:0]              match_position_q;
	logic                     eq;
	logic                     take;
	logic                     hit_seen_n;
	logic [POSITION_BITS-1:0] hit_pos_n;

	always_comb begin
		new_win[0] = entry_byte;
		for (int k = 1; k < MAX_QUERY; k++) begin
			new_win[k] = win_q[k-1];
		end
	end

	// window entry k lines up with pattern byte len-1-k
	always_comb begin
		logic [ssc_pkg::LEN_W-1:0] pidx;
		eq   = 1'b1;
		pidx = '0;
		for (int k = 0; k < MAX_QUERY; k++) begin
			if (k < int'(query_len)) begin
				pidx = ssc_pkg::LEN_W'(int'(query_len) - 1 - k);
				if (new_win[k] != ssc_pkg::fold_byte(ssc_pkg::pattern_byte(pat_lo, pat_hi, pidx),
						case_fold)) begin
					eq = 1'b0;
				end
			end
		end
	end

	always_comb begin
		if (backward_mode) begin
			take = entry_flags.cand && eq && entry_flags.at_or_before;
		end else begin
			take = entry_flags.cand && eq && !hit_seen_q && entry_flags.at_or_after;
		end
		hit_seen_n = hit_seen_q || take;
		hit_pos_n  = take ? entry_pos : hit_pos_q;
	end

	assign entry_pop = entry_valid && (!entry_flags.last || !result_valid_q || result_ready);

	always_ff @(posedge clk) begin
		if (entry_pop) begin
			for (int k = 0; k < MAX_QUERY; k++) begin
				win_q[k] <= new_win[k];
			end
			hit_pos_q <= entry_flags.last ? '0 : hit_pos_n;
			if (entry_flags.last) begin
				if (query_len == '0) begin
					found_q          <= 1'b1;
					match_position_q <= start_position;
				end else if (hit_seen_n) begin
					found_q          <= 1'b1;
					match_position_q <= 32'(hit_pos_n);
				end else begin
					found_q          <= 1'b0;
					match_position_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_seen_q     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (entry_pop) begin
				hit_seen_q <= entry_flags.last ? 1'b0 : hit_seen_n;
			end
			if (entry_pop && entry_flags.last) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid   = result_valid_q;
	assign found          = found_q;
	assign match_position = match_position_q;

endmodule

// ===== rtl/substring_search_cased_core.sv =====
// top level of the streaming substring search core with optional case folding
`timescale 1ns / 1ps

// Streaming substring search. Text bytes arrive one per transaction, position 0
// first, last_byte marking the end of the text; exactly one result transaction
// (found, match_position) follows each last byte. The core sustains one byte per
// cycle while the queue has room: the front end folds case, keeps the saturating
// position counter and classifies each byte against start_position, a two-entry
// queue decouples it from the back end, and the back end compares the whole byte
// window with the pattern combinationally. The result is registered as the back
// end takes the last byte, which waits until the output is free; a stalled result
// holds back only the last byte of the next text. Registers sit at byte address
// 8*i on a 64-bit APB port and must be written only while no text is in flight.
module substring_search_cased_core #(
	parameter int MAX_QUERY     = 16,
	parameter int POSITION_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            text_valid,
	output logic                            text_ready,
	input  logic [7:0]                      text_byte,
	input  logic                            last_byte,
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic                            found,
	output logic [31:0]                     match_position,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ssc_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [ssc_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [ssc_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                            pready
);

	localparam int QW = 8 + POSITION_BITS + ssc_pkg::FLAGS_W;

	logic                          case_fold_q;
	logic                          backward_mode_q;
	logic [ssc_pkg::LEN_W-1:0]     pattern_length_q;
	logic [63:0]                   pat_lo_q;
	logic [63:0]                   pat_hi_q;
	logic [31:0]                   start_position_q;
	logic [ssc_pkg::LEN_W-1:0]     qlen;
	ssc_pkg::reg_idx_t             reg_idx;
	logic                          cfg_write;

	logic                          push_valid;
	logic [7:0]                    push_byte;
	logic [POSITION_BITS-1:0]      push_pos;
	ssc_pkg::item_flags_t          push_flags;
	logic                          pop_valid;
	logic [QW-1:0]                 pop_data;
	logic                          entry_pop;
	logic [7:0]                    entry_byte;
	logic [POSITION_BITS-1:0]      entry_pos;
	ssc_pkg::item_flags_t          entry_flags;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign reg_idx   = ssc_pkg::reg_idx_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			case_fold_q      <= 1'b0;
			backward_mode_q  <= 1'b0;
			pattern_length_q <= '0;
			pat_lo_q         <= '0;
			pat_hi_q         <= '0;
			start_position_q <= '0;
		end else if (cfg_write) begin
			case (reg_idx)
				ssc_pkg::REG_CASE_FOLD: case_fold_q      <= pwdata[0];
				ssc_pkg::REG_BACKWARD:  backward_mode_q  <= pwdata[0];
				ssc_pkg::REG_PAT_LEN:   pattern_length_q <= pwdata[ssc_pkg::LEN_W-1:0];
				ssc_pkg::REG_PAT_LO:    pat_lo_q         <= pwdata;
				ssc_pkg::REG_PAT_HI:    pat_hi_q         <= pwdata;
				ssc_pkg::REG_START:     start_position_q <= pwdata[31:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			ssc_pkg::REG_CASE_FOLD: prdata = 64'(case_fold_q);
			ssc_pkg::REG_BACKWARD:  prdata = 64'(backward_mode_q);
			ssc_pkg::REG_PAT_LEN:   prdata = 64'(pattern_length_q);
			ssc_pkg::REG_PAT_LO:    prdata = pat_lo_q;
			ssc_pkg::REG_PAT_HI:    prdata = pat_hi_q;
			ssc_pkg::REG_START:     prdata = 64'(start_position_q);
			default:                prdata = '0;
		endcase
	end

	// pattern length clamped to the window depth
	assign qlen = (int'(pattern_length_q) > MAX_QUERY) ? ssc_pkg::LEN_W'(MAX_QUERY)
		: pattern_length_q;

	ssc_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.text_valid     (text_valid),
		.text_byte      (text_byte),
		.last_byte      (last_byte),
		.queue_ready    (text_ready),
		.case_fold      (case_fold_q),
		.query_len      (qlen),
		.start_position (start_position_q),
		.push_valid     (push_valid),
		.push_byte      (push_byte),
		.push_pos       (push_pos),
		.push_flags     (push_flags)
	);

	ssc_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  ({push_byte, push_pos, push_flags}),
		.push_ready (text_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop        (entry_pop)
	);

	assign {entry_byte, entry_pos, entry_flags} = pop_data;

	ssc_back #(
		.MAX_QUERY     (MAX_QUERY),
		.POSITION_BITS (POSITION_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.entry_valid    (pop_valid),
		.entry_byte     (entry_byte),
		.entry_pos      (entry_pos),
		.entry_flags    (entry_flags),
		.entry_pop      (entry_pop),
		.case_fold      (case_fold_q),
		.backward_mode  (backward_mode_q),
		.query_len      (qlen),
		.pat_lo         (pat_lo_q),
		.pat_hi         (pat_hi_q),
		.start_position (start_position_q),
		.result_ready   (result_ready),
		.result_valid   (result_valid),
		.found          (found),
		.match_position (match_position)
	);

	a_no_match_zero_pos: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !found |-> match_position == 32'd0)
		else $error("match_position not zero without a match");

	a_empty_pattern_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (qlen == '0) |-> found && (match_position == start_position_q))
		else $error("empty pattern not reported at start position");

endmodule

// ===== sim/substring_search_cased_checker.sv =====
// checker for the substring search core: predicts each search answer and compares results
`timescale 1ns / 1ps

module substring_search_cased_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           text_valid,
	input  logic                           text_ready,
	input  logic [7:0]                     text_byte,
	input  logic                           last_byte,
	input  logic                           result_valid,
	input  logic                           result_ready,
	input  logic                           found,
	input  logic [31:0]                    match_position,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic                           pready,
	input  logic [ssc_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [ssc_pkg::CFG_DATA_W-1:0] pwdata,
	output int                             mismatches,
	output int                             outstanding,
	output int                             results_checked,
	output int                             hits_checked
);

	localparam int WIN = ssc_pkg::PAT_BYTES;

	typedef struct packed {
		logic        found;
		logic [31:0] pos;
	} search_answer_t;

	logic        fold_en;
	logic        search_back;
	logic [4:0]  pat_len;
	logic [63:0] pat_lo;
	logic [63:0] pat_hi;
	logic [31:0] start_pos;

	logic [7:0]  win [WIN];
	logic [31:0] byte_pos;
	logic        hit_valid;
	logic [31:0] hit_pos;

	search_answer_t search_answers [$];
	int errs;
	int n_results;
	int n_hits;

	function automatic logic [7:0] fold_char(input logic [7:0] c, input logic en);
		return (en && c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
	endfunction

	function automatic logic [7:0] pattern_char(input int i);
		logic [127:0] pat;
		pat = {pat_hi, pat_lo};
		return pat[8*i +: 8];
	endfunction

	task automatic clear_text();
		int i;
		for (i = 0; i < WIN; i++) begin
			win[i] = 8'h00;
		end
		byte_pos = '0;
		hit_valid = 1'b0;
		hit_pos = '0;
	endtask

	task automatic scan_byte(input logic [7:0] b, input logic fin);
		int q;
		int i;
		logic [32:0] count_after;
		logic [31:0] pos;
		logic eq;
		search_answer_t ans;
		q = (pat_len > 5'd16) ? 16 : int'(pat_len);
		count_after = {1'b0, byte_pos} + 33'd1;
		for (i = WIN - 1; i > 0; i--) begin
			win[i] = win[i-1];
		end
		win[0] = b;
		if (byte_pos != '1) begin
			byte_pos = byte_pos + 32'd1;
		end
		if (q > 0 && count_after >= 33'(q)) begin
			pos = 32'(count_after - 33'(q));
			eq = 1'b1;
			for (i = 0; i < q; i++) begin
				if (fold_char(win[q-1-i], fold_en) != fold_char(pattern_char(i), fold_en)) begin
					eq = 1'b0;
				end
			end
			if (eq) begin
				if (!search_back) begin
					if (!hit_valid && pos >= start_pos) begin
						hit_valid = 1'b1;
						hit_pos = pos;
					end
				end else if (pos <= start_pos) begin
					hit_valid = 1'b1;
					hit_pos = pos;
				end
			end
		end
		if (fin) begin
			if (q == 0) begin
				ans = '{found: 1'b1, pos: start_pos};
			end else if (hit_valid) begin
				ans = '{found: 1'b1, pos: hit_pos};
			end else begin
				ans = '{found: 1'b0, pos: 32'd0};
			end
			search_answers.push_back(ans);
			clear_text();
		end
	endtask

	task automatic check_result();
		search_answer_t ans;
		n_results++;
		if (search_answers.size() == 0) begin
			errs++;
			if (errs <= 10) begin
				$display("result with no search pending: found=%0b position=%0d",
					found, match_position);
			end
		end else begin
			ans = search_answers.pop_front();
			if (found !== ans.found || match_position !== ans.pos) begin
				errs++;
				if (errs <= 10) begin
					$display("result %0d: expected found=%0b pos=%0d, got found=%0b pos=%0d",
						n_results, ans.found, ans.pos, found, match_position);
				end
			end
			if (ans.found) begin
				n_hits++;
			end
		end
	endtask

	task automatic write_register(input logic [2:0] idx, input logic [63:0] value);
		case (ssc_pkg::reg_idx_t'(idx))
			ssc_pkg::REG_CASE_FOLD: fold_en = value[0];
			ssc_pkg::REG_BACKWARD:  search_back = value[0];
			ssc_pkg::REG_PAT_LEN:   pat_len = value[4:0];
			ssc_pkg::REG_PAT_LO:    pat_lo = value;
			ssc_pkg::REG_PAT_HI:    pat_hi = value;
			ssc_pkg::REG_START:     start_pos = value[31:0];
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_en = 1'b0;
			search_back = 1'b0;
			pat_len = '0;
			pat_lo = '0;
			pat_hi = '0;
			start_pos = '0;
			clear_text();
			search_answers.delete();
			errs = 0;
			n_results = 0;
			n_hits = 0;
		end else begin
			if (text_valid && text_ready) begin
				scan_byte(text_byte, last_byte);
			end
			if (result_valid && result_ready) begin
				check_result();
			end
			if (psel && penable && pwrite && pready) begin
				write_register(paddr[ssc_pkg::CFG_ADDR_W-1:3], pwdata);
			end
		end
		mismatches <= errs;
		outstanding <= search_answers.size();
		results_checked <= n_results;
		hits_checked <= n_hits;
	end

endmodule

// ===== sim/substring_search_cased_core_tb.sv =====
// testbench top for the substring search core: stimulus, register setup and verdict
`timescale 1ns / 1ps

module substring_search_cased_core_tb;

	localparam int PHASES          = 20;
	localparam int BYTES_PER_PHASE = 52;
	localparam int IDLE_LIMIT      = 5000;
	localparam int SETTLE_CYCLES   = 8;
	localparam logic [2:0] UNUSED_REG_IDX = 3'd7;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	logic                           clk;
	logic                           arst_n;
	logic                           text_valid;
	logic                           text_ready;
	logic [7:0]                     text_byte;
	logic                           last_byte;
	logic                           result_valid;
	logic                           result_ready;
	logic                           found;
	logic [31:0]                    match_position;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [ssc_pkg::CFG_ADDR_W-1:0] paddr;
	logic [ssc_pkg::CFG_DATA_W-1:0] pwdata;
	logic [ssc_pkg::CFG_DATA_W-1:0] prdata;
	logic                           pready;

	int mismatches;
	int outstanding;
	int results_checked;
	int hits_checked;

	int send_idle_pct;
	int recv_stall_pct;
	int bytes_sent;
	int texts_sent;
	int settings_used;
	int stuck;

	logic [7:0] pat_bytes [16];
	int         eff_len;
	logic       binary_set;

	substring_search_cased_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.text_valid     (text_valid),
		.text_ready     (text_ready),
		.text_byte      (text_byte),
		.last_byte      (last_byte),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.found          (found),
		.match_position (match_position),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	substring_search_cased_checker search_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.text_valid      (text_valid),
		.text_ready      (text_ready),
		.text_byte       (text_byte),
		.last_byte       (last_byte),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.found           (found),
		.match_position  (match_position),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.results_checked (results_checked),
		.hits_checked    (hits_checked)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (text_valid && text_ready) || (result_valid && result_ready) ||
				(psel && penable)) begin
			stuck <= 0;
		end else if (stuck >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			stuck <= stuck + 1;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			text_valid <= 1'b0;
			@(posedge clk);
		end
		text_valid <= 1'b1;
		text_byte <= b;
		last_byte <= fin;
		@(posedge clk);
		while (!text_ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_str(input string s);
		int i;
		for (i = 0; i < s.len(); i++) begin
			send_byte(s[i], i == s.len() - 1);
		end
		texts_sent++;
	endtask

	// wait for every answer, then let the pipeline empty before touching registers
	task automatic drain_results();
		text_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_char(input logic binary);
		logic [7:0] c;
		if (binary) begin
			c = $urandom_range(1) ? 8'hFF : 8'h00;
		end else begin
			case ($urandom_range(5))
				0: c = 8'h61;
				1: c = 8'h62;
				2: c = 8'h41;
				3: c = 8'h42;
				4: c = 8'h40;
				default: c = 8'h5B;
			endcase
		end
		return c;
	endfunction

	function automatic logic [7:0] flip_case(input logic [7:0] c);
		logic is_letter;
		is_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
		return (is_letter && $urandom_range(4) == 0) ? (c ^ 8'h20) : c;
	endfunction

	task automatic configure_phase(input int ph);
		logic        fold_v;
		logic        back_v;
		logic [4:0]  len_v;
		logic [31:0] start_v;
		logic [63:0] lo_v;
		logic [63:0] hi_v;
		int          i;
		idle_mode_t  mode;
		binary_set = (ph % 3 == 2);
		fold_v = 1'($urandom_range(1));
		back_v = 1'($urandom_range(1));
		case (ph % 6)
			0: len_v = 5'($urandom_range(1, 3));
			1: len_v = 5'($urandom_range(4, 8));
			2: len_v = 5'd16;
			3: len_v = 5'($urandom_range(17, 31));
			4: len_v = 5'd0;
			default: len_v = 5'($urandom_range(1, 2));
		endcase
		case (ph % 7)
			0: start_v = 32'd0;
			1: start_v = 32'hFFFF_FFFF;
			default: start_v = $urandom_range(0, 40);
		endcase
		for (i = 0; i < 16; i++) begin
			pat_bytes[i] = pick_char(binary_set);
			if (ph == 5) begin
				pat_bytes[i] = 8'h00;
			end else if (ph == 11) begin
				pat_bytes[i] = 8'hFF;
			end
		end
		for (i = 0; i < 8; i++) begin
			lo_v[8*i +: 8] = pat_bytes[i];
			hi_v[8*i +: 8] = pat_bytes[i+8];
		end
		eff_len = (len_v > 5'd16) ? 16 : int'(len_v);
		write_reg(ssc_pkg::REG_CASE_FOLD, {63'd0, fold_v});
		write_reg(ssc_pkg::REG_BACKWARD, {63'd0, back_v});
		write_reg(ssc_pkg::REG_PAT_LEN, {59'd0, len_v});
		write_reg(ssc_pkg::REG_PAT_LO, lo_v);
		write_reg(ssc_pkg::REG_PAT_HI, hi_v);
		write_reg(ssc_pkg::REG_START, {32'd0, start_v});
		mode = idle_mode_t'(ph % 4);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			IDLE_SENDER: begin
				send_idle_pct = 76;
				recv_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct = 0;
				recv_stall_pct = 76;
			end
			default: begin
				send_idle_pct = 22;
				recv_stall_pct = 22;
			end
		endcase
		settings_used++;
	endtask

	// texts mostly hold one or two copies of the pattern, some with flipped case or noise
	task automatic send_random_text();
		logic [7:0] text_buf [64];
		int tlen;
		int i;
		int k;
		int at;
		int copies;
		if ($urandom_range(9) < 7) begin
			tlen = ((eff_len > 0) ? eff_len : 1) + $urandom_range(10);
		end else begin
			tlen = $urandom_range(1, 40);
		end
		for (i = 0; i < tlen; i++) begin
			text_buf[i] = pick_char(binary_set);
		end
		if (eff_len > 0 && eff_len <= tlen && $urandom_range(9) < 7) begin
			copies = $urandom_range(1, 2);
			for (k = 0; k < copies; k++) begin
				at = $urandom_range(tlen - eff_len);
				for (i = 0; i < eff_len; i++) begin
					text_buf[at+i] = flip_case(pat_bytes[i]);
				end
			end
		end
		for (i = 0; i < tlen; i++) begin
			if ($urandom_range(24) == 0) begin
				text_buf[i] = 8'($urandom_range(255));
			end
		end
		for (i = 0; i < tlen; i++) begin
			send_byte(text_buf[i], i == tlen - 1);
		end
		texts_sent++;
	endtask

	initial begin
		int ph;
		int phase_start;
		arst_n = 1'b0;
		text_valid = 1'b0;
		text_byte = 8'h00;
		last_byte = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		bytes_sent = 0;
		texts_sent = 0;
		settings_used = 1;
		eff_len = 0;
		binary_set = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: empty pattern found at position zero, unused address ignored
		write_reg(UNUSED_REG_IDX, '1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		texts_sent++;
		drain_results();

		// folded two-byte pattern with start beyond the text
		write_reg(ssc_pkg::REG_CASE_FOLD, 64'd1);
		write_reg(ssc_pkg::REG_PAT_LEN, 64'd2);
		write_reg(ssc_pkg::REG_PAT_LO, 64'h0000_0000_0000_417A);
		write_reg(ssc_pkg::REG_PAT_HI, '1);
		write_reg(ssc_pkg::REG_START, 64'hFFFF_FFFF);
		send_str("Za");
		drain_results();

		// bytes around the letter ranges must not fold
		write_reg(ssc_pkg::REG_START, 64'd0);
		send_byte(8'h60, 1'b0);
		send_str("@[{Za");
		drain_results();

		// exact compare
		write_reg(ssc_pkg::REG_CASE_FOLD, 64'd0);
		send_str("zazA");
		drain_results();

		// backward search keeps the last match at or before start
		write_reg(ssc_pkg::REG_CASE_FOLD, 64'd1);
		write_reg(ssc_pkg::REG_BACKWARD, 64'd1);
		write_reg(ssc_pkg::REG_PAT_LEN, 64'd1);
		write_reg(ssc_pkg::REG_PAT_LO, 64'h61);
		write_reg(ssc_pkg::REG_START, 64'd3);
		send_str("AaXa");
		drain_results();

		// oversized length clamps to the full window, longer than the text
		write_reg(ssc_pkg::REG_PAT_LEN, 64'd31);
		send_str("abc");
		drain_results();

		// empty pattern with start past the end of the text
		write_reg(ssc_pkg::REG_PAT_LEN, 64'd0);
		write_reg(ssc_pkg::REG_START, 64'd1000);
		send_str("q");
		drain_results();
		settings_used += 6;

		for (ph = 0; ph < PHASES; ph++) begin
			configure_phase(ph);
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < BYTES_PER_PHASE) begin
				send_random_text();
			end
			drain_results();
		end

		$display("covered %0d bytes in %0d texts, %0d register settings, four idle patterns",
			bytes_sent, texts_sent, settings_used);
		$display("%0d results checked, %0d reporting a match, %0d mismatches",
			results_checked, hits_checked, mismatches);
		if (mismatches == 0 && outstanding == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/ssc_pkg.sv
rtl/ssc_front.sv
rtl/ssc_queue.sv
rtl/ssc_back.sv
rtl/substring_search_cased_core.sv
sim/substring_search_cased_checker.sv
sim/substring_search_cased_core_tb.sv
